[rtl/subpage_slab_allocator_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sub-page slab allocator
// Each macro expands to a concurrent assertion in simulation and to nothing
// in synthesis.
// ----------------------------------------------------------------------------
`ifndef SUBPAGE_SLAB_ALLOCATOR_TOP_MACROS_SVH
`define SUBPAGE_SLAB_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define SSA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("assertion failed");
// expr must never be true out of reset
`define SSA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define SSA_ASSERT(lbl, clk, rst_n, prop)
`define SSA_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[rtl/ssa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared constants and types of the sub-page slab allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

	localparam int DEF_MAX_ENTRIES = 256;
	localparam int SLOTS           = 16;
	localparam int SLOT_W          = 4;
	localparam int SLOT_SHIFT      = 12;
	localparam int PAGE_W          = 16;
	localparam int LEN_W           = 17;
	localparam int ADDR_W          = 32;
	localparam int LIMIT_W         = 17;

	localparam logic [SLOTS-1:0]   FULL_MASK      = 16'hFFFF;
	localparam logic [LEN_W-1:0]   PAGE_BYTES     = 17'h10000;
	localparam logic [LEN_W-1:0]   SLOT_ROUND     = 17'd4095;
	localparam logic [PAGE_W-1:0]  INIT_PAGES_RST = 16'd1;
	localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RST = 17'h10000;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOMEM     = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		CFG_INITIAL_PAGES = 1'b0,
		CFG_PAGE_LIMIT    = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] start;
	} fit_t;

endpackage
`default_nettype wire

[rtl/ssa_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssa request and response channels
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
interface ssa_req_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [ssa_pkg::LEN_W-1:0]   length_bytes;
	logic [ssa_pkg::ADDR_W-1:0]  free_address;

	modport source (output valid, output cmd, output length_bytes, output free_address,
		input ready);
	modport sink (input valid, input cmd, input length_bytes, input free_address,
		output ready);
endinterface

interface ssa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ssa_pkg::ADDR_W-1:0]  address;
	logic [1:0]                  status;

	modport source (output valid, output address, output status, input ready);
	modport sink (input valid, input address, input status, output ready);
endinterface
`default_nettype wire

[rtl/subpage_slab_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// subpage_slab_allocator_top
// Bitmap slab allocator: 4 KB slots in 64 KB slabs, one table RAM.
// ----------------------------------------------------------------------------
// One request at a time. The slab table (page, slot bitmap, list link and
// flags per entry) lives in a single RAM with registered read data; the
// sequencer reads, modifies and writes it back. A request walks the partial
// list, scans the table for a free entry or a matching page, and walks the
// list again when a slab leaves the partial list. Entries are tracked by a
// fill count, so there is no clearing pass after reset. A finished result
// waits in an output register while the next request is taken.
// ----------------------------------------------------------------------------
`include "subpage_slab_allocator_top_macros.svh"

module subpage_slab_allocator_top #(
	parameter int MAX_ENTRIES = ssa_pkg::DEF_MAX_ENTRIES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [ssa_pkg::LIMIT_W-1:0]   cfg_wdata,
	ssa_req_if.sink                            req,
	ssa_rsp_if.source                          rsp
);

	localparam int LW   = $clog2(MAX_ENTRIES + 1);
	localparam int AW   = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
	localparam int P_LO = ssa_pkg::SLOTS;
	localparam int N_LO = ssa_pkg::SLOTS + ssa_pkg::PAGE_W;
	localparam int ON_B = N_LO + LW;
	localparam int V_B  = ON_B + 1;
	localparam int WW   = V_B + 1;
	localparam logic [LW-1:0] LEND = LW'(MAX_ENTRIES);

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, A_RD, A_CHK, U_RD, U_CHK, U_WP, W_E,
		G_CHK, G_RD, G_SCN, G_WR, F_RD, F_SCN, S_DONE
	} state_t;

	function automatic logic [WW-1:0] mkw(input logic v, input logic on,
		input logic [LW-1:0] nx, input logic [ssa_pkg::PAGE_W-1:0] pg,
		input logic [ssa_pkg::SLOTS-1:0] mk);
		mkw = {v, on, nx, pg, mk};
	endfunction

	state_t state_q;

	logic [ssa_pkg::PAGE_W-1:0]  init_pages_q;
	logic [ssa_pkg::LIMIT_W-1:0] page_limit_q;

	logic                         cmd_q;
	logic [ssa_pkg::LEN_W-1:0]    len_q;
	logic [ssa_pkg::ADDR_W-1:0]   faddr_q;
	logic [ssa_pkg::SLOT_W:0]     n_q;

	logic [LW-1:0]                head_q, touched_q, cur_q, prev_q, steps_q, ent_q, nxt_e_q;
	logic [ssa_pkg::LIMIT_W-1:0]  grown_q;
	logic [ssa_pkg::PAGE_W-1:0]   gpage_q;
	logic [WW-1:0]                prev_word_q, ent_word_q;
	logic [ssa_pkg::ADDR_W-1:0]   res_addr_q;
	ssa_pkg::status_t             res_status_q;

	logic                         out_valid_q;
	logic [ssa_pkg::ADDR_W-1:0]   out_addr_q;
	ssa_pkg::status_t             out_status_q;

	logic                         ram_we, ram_re;
	logic [AW-1:0]                ram_waddr, ram_raddr;
	logic [WW-1:0]                ram_wdata, ram_rdata;

	logic [ssa_pkg::SLOTS-1:0]    rd_mask;
	logic [ssa_pkg::PAGE_W-1:0]   rd_page;
	logic [LW-1:0]                rd_next;
	logic                         rd_on, rd_valid;
	ssa_pkg::fit_t                fit;

	logic [ssa_pkg::SLOTS-1:0]    run_w, take_m, alloc_mask, free_m, kept_mask;
	logic [ssa_pkg::LEN_W-1:0]    len1, len_up;
	logic [ssa_pkg::LIMIT_W-1:0]  limit_w, page_w;
	logic                         slab_full, pushed;

	assign rd_mask  = ram_rdata[P_LO-1:0];
	assign rd_page  = ram_rdata[N_LO-1:P_LO];
	assign rd_next  = ram_rdata[ON_B-1:N_LO];
	assign rd_on    = ram_rdata[ON_B];
	assign rd_valid = ram_rdata[V_B];

	ssa_fit u_fit (
		.mask (rd_mask),
		.n    (n_q),
		.fit  (fit)
	);

	always_comb begin
		run_w      = ssa_pkg::SLOTS'((17'h1 << n_q) - 17'h1);
		take_m     = run_w << fit.start;
		alloc_mask = rd_mask | take_m;
		free_m     = run_w << faddr_q[15:12];
		kept_mask  = rd_mask & ~free_m;
		slab_full  = rd_mask == ssa_pkg::FULL_MASK;
		pushed     = slab_full && (kept_mask != ssa_pkg::FULL_MASK) && !rd_on;
		len1       = (len_q == '0) ? ssa_pkg::LEN_W'(1) : len_q;
		len_up     = len_q + ssa_pkg::SLOT_ROUND;
		limit_w    = (page_limit_q > ssa_pkg::PAGE_BYTES) ? ssa_pkg::PAGE_BYTES : page_limit_q;
		page_w     = ssa_pkg::LIMIT_W'(init_pages_q) + grown_q;
	end

	// table RAM access per state
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = cur_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = ent_q[AW-1:0];
		ram_wdata = ent_word_q;
		unique case (state_q)
			A_RD:  ram_re = (steps_q < LEND) && (cur_q < LEND);
			U_RD:  ram_re = (steps_q < LEND) && (cur_q < LEND) && (cur_q != ent_q);
			G_RD:  ram_re = cur_q < touched_q;
			F_RD:  ram_re = cur_q < touched_q;
			U_WP: begin
				ram_we    = 1'b1;
				ram_waddr = prev_q[AW-1:0];
				ram_wdata = {prev_word_q[WW-1:ON_B], nxt_e_q, prev_word_q[N_LO-1:0]};
			end
			W_E:   ram_we = 1'b1;
			G_WR: begin
				ram_we    = 1'b1;
				ram_wdata = (run_w != ssa_pkg::FULL_MASK) ?
					mkw(1'b1, 1'b1, head_q, gpage_q, run_w) :
					mkw(1'b1, 1'b0, LEND, gpage_q, run_w);
			end
			default: ;
		endcase
	end

	ssa_ram #(
		.WIDTH (WW),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_pages_q <= ssa_pkg::INIT_PAGES_RST;
			page_limit_q <= ssa_pkg::PAGE_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == ssa_pkg::CFG_INITIAL_PAGES)
				init_pages_q <= cfg_wdata[ssa_pkg::PAGE_W-1:0];
			else
				page_limit_q <= cfg_wdata;
		end
	end

	assign req.ready   = state_q == S_IDLE;
	assign rsp.valid   = out_valid_q;
	assign rsp.address = out_addr_q;
	assign rsp.status  = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= LEND;
			touched_q    <= '0;
			grown_q      <= '0;
			out_valid_q  <= 1'b0;
			out_addr_q   <= '0;
			out_status_q <= ssa_pkg::ST_OK;
			cmd_q        <= 1'b0;
			len_q        <= '0;
			faddr_q      <= '0;
			n_q          <= '0;
			cur_q        <= '0;
			prev_q       <= '0;
			steps_q      <= '0;
			ent_q        <= '0;
			nxt_e_q      <= '0;
			gpage_q      <= '0;
			prev_word_q  <= '0;
			ent_word_q   <= '0;
			res_addr_q   <= '0;
			res_status_q <= ssa_pkg::ST_OK;
		end else begin
			// S_DONE reloads the output register itself
			if (out_valid_q && rsp.ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q   <= req.cmd;
						len_q   <= req.length_bytes;
						faddr_q <= req.free_address;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					res_addr_q   <= '0;
					res_status_q <= ssa_pkg::ST_OK;
					steps_q      <= '0;
					if (cmd_q == ssa_pkg::CMD_ALLOC) begin
						cur_q <= head_q;
						n_q <= 5'((len1 - 17'd1) >> ssa_pkg::SLOT_SHIFT) + 5'd1;
						if (len1 > ssa_pkg::PAGE_BYTES) begin
							res_status_q <= ssa_pkg::ST_TOO_LARGE;
							state_q      <= S_DONE;
						end else
							state_q <= A_RD;
					end else begin
						n_q   <= 5'(len_up >> ssa_pkg::SLOT_SHIFT);
						cur_q <= '0;
						if (faddr_q == '0 || faddr_q == '1)
							state_q <= S_DONE;
						else if (len_q > ssa_pkg::PAGE_BYTES) begin
							res_status_q <= ssa_pkg::ST_TOO_LARGE;
							state_q      <= S_DONE;
						end else
							state_q <= F_RD;
					end
				end
				A_RD: begin
					if (steps_q < LEND && cur_q < LEND)
						state_q <= A_CHK;
					else
						state_q <= G_CHK;
				end
				A_CHK: begin
					if (fit.found) begin
						res_addr_q <= {rd_page, fit.start, 12'h000};
						ent_q      <= cur_q;
						nxt_e_q    <= rd_next;
						if (alloc_mask == ssa_pkg::FULL_MASK && rd_on) begin
							// slab is now full: drop it from the partial list
							ent_word_q <= mkw(rd_valid, 1'b0, LEND, rd_page, alloc_mask);
							cur_q      <= head_q;
							prev_q     <= LEND;
							steps_q    <= '0;
							state_q    <= U_RD;
						end else begin
							ent_word_q <= {ram_rdata[WW-1:P_LO], alloc_mask};
							state_q    <= W_E;
						end
					end else begin
						cur_q   <= rd_next;
						steps_q <= steps_q + 1'b1;
						state_q <= A_RD;
					end
				end
				U_RD: begin
					if (steps_q >= LEND || cur_q >= LEND)
						state_q <= W_E;
					else if (cur_q == ent_q) begin
						if (prev_q == LEND) begin
							head_q  <= nxt_e_q;
							state_q <= W_E;
						end else
							state_q <= U_WP;
					end else
						state_q <= U_CHK;
				end
				U_CHK: begin
					prev_q      <= cur_q;
					prev_word_q <= ram_rdata;
					cur_q       <= rd_next;
					steps_q     <= steps_q + 1'b1;
					state_q     <= U_RD;
				end
				U_WP: state_q <= W_E;
				W_E:  state_q <= S_DONE;
				G_CHK: begin
					if ({1'b0, page_w} + 18'd1 > {1'b0, limit_w}) begin
						res_status_q <= ssa_pkg::ST_NOMEM;
						state_q      <= S_DONE;
					end else begin
						grown_q <= grown_q + 1'b1;
						gpage_q <= page_w[ssa_pkg::PAGE_W-1:0];
						cur_q   <= '0;
						state_q <= G_RD;
					end
				end
				G_RD: begin
					if (cur_q < touched_q)
						state_q <= G_SCN;
					else if (touched_q >= LEND) begin
						res_status_q <= ssa_pkg::ST_NOMEM;
						state_q      <= S_DONE;
					end else begin
						ent_q     <= touched_q;
						touched_q <= touched_q + 1'b1;
						state_q   <= G_WR;
					end
				end
				G_SCN: begin
					if (!rd_valid) begin
						ent_q   <= cur_q;
						state_q <= G_WR;
					end else begin
						cur_q   <= cur_q + 1'b1;
						state_q <= G_RD;
					end
				end
				G_WR: begin
					if (run_w != ssa_pkg::FULL_MASK)
						head_q <= ent_q;
					res_addr_q <= {gpage_q, 16'h0000};
					state_q    <= S_DONE;
				end
				F_RD: begin
					if (cur_q < touched_q)
						state_q <= F_SCN;
					else begin
						res_status_q <= ssa_pkg::ST_NOT_FOUND;
						state_q      <= S_DONE;
					end
				end
				F_SCN: begin
					if (rd_valid && rd_page == faddr_q[31:16]) begin
						ent_q   <= cur_q;
						nxt_e_q <= rd_next;
						if (kept_mask == '0 && rd_on) begin
							ent_word_q <= mkw(1'b0, 1'b0, LEND, rd_page, '0);
							cur_q      <= head_q;
							prev_q     <= LEND;
							steps_q    <= '0;
							state_q    <= U_RD;
						end else begin
							state_q <= W_E;
							if (kept_mask == '0) begin
								if (pushed)
									// pushed and unlinked at once: head stays
									ent_word_q <= mkw(1'b0, 1'b0, LEND, rd_page, '0);
								else
									ent_word_q <= mkw(1'b0, rd_on, rd_next, rd_page, '0);
							end else if (pushed) begin
								ent_word_q <= mkw(1'b1, 1'b1, head_q, rd_page, kept_mask);
								head_q     <= cur_q;
							end else
								ent_word_q <= {ram_rdata[WW-1:P_LO], kept_mask};
						end
					end else begin
						cur_q   <= cur_q + 1'b1;
						state_q <= F_RD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_addr_q   <= res_addr_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SSA_ASSERT_NEVER(a_touched_bound, clk, arst_n, touched_q > LEND)
	`SSA_ASSERT_NEVER(a_grown_bound, clk, arst_n, grown_q > ssa_pkg::PAGE_BYTES)
	`SSA_ASSERT_NEVER(a_no_write_idle, clk, arst_n, ram_we && state_q == S_IDLE)
	`SSA_ASSERT_NEVER(a_fail_zero_addr, clk, arst_n, out_valid_q && out_status_q != ssa_pkg::ST_OK && out_addr_q != '0)

endmodule
`default_nettype wire

[rtl/ssa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/ssa_fit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_fit
// Finds the lowest slot where a run of n free slots fits in a slot bitmap.
// ----------------------------------------------------------------------------
module ssa_fit (
	input  wire logic [ssa_pkg::SLOTS-1:0]  mask,
	input  wire logic [ssa_pkg::SLOT_W:0]   n,
	output ssa_pkg::fit_t                   fit
);

	logic [ssa_pkg::SLOTS-1:0] run;
	logic [ssa_pkg::SLOTS-1:0] cand;

	assign run = ssa_pkg::SLOTS'((17'h1 << n) - 17'h1);

	always_comb begin
		for (int s = 0; s < ssa_pkg::SLOTS; s++)
			cand[s] = ((s + int'(n)) <= ssa_pkg::SLOTS) && ((mask & (run << s)) == '0);
	end

	// lowest candidate wins
	always_comb begin
		fit = '0;
		for (int s = ssa_pkg::SLOTS - 1; s >= 0; s--) begin
			if (cand[s]) begin
				fit.found = 1'b1;
				fit.start = ssa_pkg::SLOT_W'(s);
			end
		end
	end

endmodule
`default_nettype wire
